// ===== src/fbfla_pkg.sv =====
// ----------------------------------------------------------------------------
// Free-list allocator package
// Shared types, sizes and codes for the fixed-size block free-list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  // Pool geometry
  localparam int Units     = 64;
  localparam int UnitBytes = 16;

  // Field widths
  localparam int IdxW = $clog2(Units);
  localparam int CntW = $clog2(Units + 1);
  localparam int ReqW = 16;

  // Operation codes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // Status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusRefused = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [ReqW-1:0] request_bytes;
    logic [IdxW-1:0] free_index;
  } req_t;

  typedef struct packed {
    logic            status;
    logic [IdxW-1:0] unit_index;
    logic [CntW-1:0] units_free;
  } rsp_t;

endpackage

// ===== src/fixed_block_free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Fixed-size block free-list allocator core
// Pops and pushes unit indices on a linked free list held in a link memory.
// ----------------------------------------------------------------------------
// A pool of equal-size units is kept as a singly linked free list. An allocate
// transaction pops the head unit and returns its index, or is refused when the
// requested byte count exceeds the free units times UNIT_BYTES or the list is
// empty. A free transaction pushes the given unit back onto the head; double
// frees are not detected. Every request gives exactly one response carrying
// the status, the allocated index (zero on refusal and on free) and the
// number of free units left. One request is processed at a time: it is taken
// in the idle state, which also reads the link memory at the current head,
// and the following lookup cycle uses the returned next pointer to update the
// list and load the response register. The response is offered from the
// cycle after the lookup and waits in that register until taken; the block
// is ready again meanwhile, so with the response side taking at once the
// next request is taken once the lookup has returned to the idle state. A
// lookup whose response register is still full holds until the waiting
// response is taken. The link memory needs no clearing pass after reset: a
// valid bit per entry marks entries written since reset, and an unwritten
// entry reads as its reset link, the following unit (the last one links to
// null).
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core #(
  parameter int UNIT_BYTES = fbfla_pkg::UnitBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fbfla_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fbfla_pkg::rsp_t out_rsp_o
);
  import fbfla_pkg::*;

  // Width of the byte limit and of the size comparison
  localparam int LimW = CntW + $clog2(UNIT_BYTES + 1);
  localparam int CmpW = (LimW > ReqW) ? LimW : ReqW;

  // Null link: one past the last unit
  localparam logic [CntW-1:0] NullLink = CntW'(Units);
  localparam logic [CntW-1:0] FullCnt  = CntW'(Units);

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;  // ready for a request
  localparam logic [1:0] StLook = 2'd1;  // link memory data available, update

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  req_t            req_q;
  rsp_t            rsp_q, rsp_d;

  // Link memory with a valid bit per entry
  logic [CntW-1:0] link_mem_q [Units];
  logic [Units-1:0] link_vld_q;
  logic [CntW-1:0] rd_data_q;
  logic            rd_vld_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;

  logic            in_accept;
  logic            out_accept;
  logic [LimW-1:0] limit;
  logic            too_big;
  logic            head_null;
  logic            idx_in_range;
  logic [CntW-1:0] link_fall;
  logic [CntW-1:0] next_head;

  assign in_accept  = in_valid_i & in_ready_o;
  assign out_accept = out_valid_o & out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Compare unit: requested bytes against free units times unit size
  assign limit     = LimW'(count_q) * LimW'(UNIT_BYTES);
  assign too_big   = CmpW'(req_q.request_bytes) > CmpW'(limit);
  assign head_null = (head_q == NullLink);
  assign idx_in_range = {1'b0, req_q.free_index} < FullCnt;

  // An unwritten entry links to the following unit
  assign link_fall = head_q + CntW'(1);
  assign next_head = rd_vld_q ? rd_data_q : link_fall;

  // Sequencer and update of the list state
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = req_q.free_index;
    // Drop the response once the transaction is taken
    if (out_accept) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StLook;
        end
      end
      StLook: begin
        // Hold while the previous response still waits in the register
        if (!out_valid_q || out_ready_i) begin
          rsp_d.status     = StatusOk;
          rsp_d.unit_index = '0;
          if (req_q.opcode == OpAlloc) begin
            if (too_big || head_null) begin
              // Refuse: leave the list untouched
              rsp_d.status = StatusRefused;
            end else begin
              // Pop the head unit
              rsp_d.unit_index = head_q[IdxW-1:0];
              head_d = next_head;
              if (count_q != '0) begin
                count_d = count_q - CntW'(1);
              end
            end
          end else if (idx_in_range) begin
            // Push the returned unit onto the head
            mem_we = 1'b1;
            head_d = {1'b0, req_q.free_index};
            if (count_q < FullCnt) begin
              count_d = count_q + CntW'(1);
            end
          end
          rsp_d.units_free = count_d;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      count_q     <= FullCnt;
      out_valid_q <= 1'b0;
      link_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        link_vld_q[mem_waddr] <= 1'b1;
      end
      if (in_accept) begin
        rd_vld_q <= link_vld_q[head_q[IdxW-1:0]];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
    rsp_q <= rsp_d;
  end

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem_q[mem_waddr] <= head_q;
    end
    if (in_accept) begin
      rd_data_q <= link_mem_q[head_q[IdxW-1:0]];
    end
  end

  // Free count never passes the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("free count exceeds pool size");

  // An accepted request blocks the input for the lookup step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("request not held in the lookup step");

  // A waiting response stays offered and unchanged until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("waiting response dropped or changed");

  // A refused allocation carries a zero index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == StatusRefused)) |-> (out_rsp_o.unit_index == '0))
    else $error("refused allocation with non-zero index");

endmodule
